FILE: hw/rtl/pfrm_pkg.sv
// ----------------------------------------------------------------------------
// Pulse flow rate meter package
// Shared payload types, register indexes and fixed constants of the meter.
// ----------------------------------------------------------------------------
`default_nettype none

package pfrm_pkg;

    // Input beat: pin sample with millisecond tick, or a clear command.
    typedef struct packed {
        logic op;
        logic pin_level;
        logic ms_tick;
    } in_t;

    // Result beat: one finished measurement window.
    typedef struct packed {
        logic [23:0] flow_ml_per_min;
        logic [47:0] total_volume_ul;
        logic [15:0] pulses_in_window;
        logic [15:0] elapsed_window_ms;
    } out_t;

    // Configuration register values as seen by the datapath.
    typedef struct packed {
        logic [15:0] window_ms;
        logic [15:0] cal_factor_q8;
    } cfg_t;

    // Status of the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Operation codes of the input beat.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Register indexes, taken from address bit 2.
    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_CAL    = 1'b1;

    // Register reset values.
    localparam logic [15:0] WINDOW_RESET = 16'd1000;
    localparam logic [15:0] CAL_RESET    = 16'd256;

    // 60000 ms/min times 256 (Q8.8 scale) and 1000 uL/mL times 256.
    localparam logic [23:0] FLOW_NUM_MULT = 24'd15360000;
    localparam logic [23:0] VOL_NUM_MULT  = 24'd256000;
    localparam int          MULT_W        = 24;

    // Saturation limits.
    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;
    localparam logic [23:0] FLOW_MAX    = 24'hFFFFFF;

    // Divisor width: elapsed milliseconds times calibration factor.
    localparam int DEN_W = 32;

endpackage

`default_nettype wire

FILE: hw/rtl/pfrm_apb_regs.sv
// ----------------------------------------------------------------------------
// Pulse flow rate meter configuration registers
// APB-style register port holding the window length and calibration factor.
// ----------------------------------------------------------------------------
`default_nettype none

module pfrm_apb_regs (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output pfrm_pkg::cfg_t          cfg
);

    logic [15:0] window_reg;
    logic [15:0] cal_reg;
    logic        wr_en;

    // The port never inserts wait states.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes on the access cycle; byte offset bits are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= pfrm_pkg::WINDOW_RESET;
            cal_reg    <= pfrm_pkg::CAL_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                pfrm_pkg::REG_WINDOW: window_reg <= pwdata[15:0];
                pfrm_pkg::REG_CAL:    cal_reg    <= pwdata[15:0];
                default:              window_reg <= window_reg;
            endcase
        end
    end

    // Read data mux.
    always_comb
    begin
        case (paddr[2])
            pfrm_pkg::REG_WINDOW: prdata = {16'd0, window_reg};
            pfrm_pkg::REG_CAL:    prdata = {16'd0, cal_reg};
            default:              prdata = 32'd0;
        endcase
    end

    assign cfg.window_ms     = window_reg;
    assign cfg.cal_factor_q8 = cal_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/pfrm_div.sv
// ----------------------------------------------------------------------------
// Pulse flow rate meter shared divider
// Radix-2 restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pfrm_div #(
    parameter int NUM_W = 40
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [NUM_W-1:0]           dividend,
    input  wire logic [pfrm_pkg::DEN_W-1:0] divisor,
    output logic      [NUM_W-1:0]           quotient,
    output pfrm_pkg::div_stat_t             stat
);

    localparam int DEN_W = pfrm_pkg::DEN_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [DEN_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        fits     = (trial >= {1'b0, dsr_reg});
        rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], fits};
    end

    // Sequencing of the steps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/pulse_flow_rate_meter_unit.sv
// ----------------------------------------------------------------------------
// Pulse flow rate meter
// Counts sensor pulses and milliseconds and reports flow and total volume.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per pin sample (op = sample) or clear command (op = clear).
//   out_* : one beat per finished measurement window.
//   APB   : window_ms at offset 0x0, cal_factor_q8 at offset 0x4; write only
//           while the meter is idle.
// Timing:
//   A sample that does not close a window, and a clear, leave the input ready
//   again in the next cycle. A sample that closes a window holds the input
//   off through load, flow divide, volume divide, accumulate and emit before
//   the result is registered. Both divides are passes through the shared
//   one-bit-per-cycle divider: flow, then volume.
// Stall:
//   The result waits in an output register; samples that close no window
//   keep flowing. A second result waits for the first to be taken.
// Reset:
//   Counts, elapsed time and total are cleared, the last pin level is taken
//   as high, and the registers return to 1000 ms and 1.0 calibration.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_flow_rate_meter_unit #(
    parameter int COUNT_WIDTH = 16,
    parameter int TOTAL_WIDTH = 48
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire pfrm_pkg::in_t  in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output pfrm_pkg::out_t      out_data,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic      [31:0]    prdata,
    output logic                pready
);

    localparam int DEN_W = pfrm_pkg::DEN_W;
    localparam int NUM_W = COUNT_WIDTH + pfrm_pkg::MULT_W;
    localparam int SUM_W = ((TOTAL_WIDTH > NUM_W) ? TOTAL_WIDTH : NUM_W) + 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

    typedef enum logic [7:0] {
        S_IDLE       = 8'b0000_0001,
        S_LOAD       = 8'b0000_0010,
        S_FLOW_START = 8'b0000_0100,
        S_FLOW_WAIT  = 8'b0000_1000,
        S_VOL_START  = 8'b0001_0000,
        S_VOL_WAIT   = 8'b0010_0000,
        S_ACCUM      = 8'b0100_0000,
        S_EMIT       = 8'b1000_0000
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic                     prev_level_reg;
    logic [COUNT_WIDTH-1:0]   count_reg;
    logic [15:0]              elapsed_reg;
    logic [TOTAL_WIDTH-1:0]   total_reg;
    logic                     out_valid_reg;
    pfrm_pkg::out_t           out_data_reg;

    logic [NUM_W-1:0]         flow_num_reg;
    logic [NUM_W-1:0]         vol_num_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [23:0]              flow_q_reg;
    logic [NUM_W-1:0]         vol_q_reg;

    pfrm_pkg::cfg_t           cfg;
    pfrm_pkg::div_stat_t      div_stat;
    logic                     div_start;
    logic [NUM_W-1:0]         div_dividend;
    logic [NUM_W-1:0]         div_quotient;

    logic                     in_fire;
    logic                     edge_seen;
    logic [COUNT_WIDTH-1:0]   count_upd;
    logic [15:0]              elapsed_upd;
    logic                     window_done;
    logic                     cal_zero;
    logic                     out_free;
    logic [SUM_W-1:0]         total_sum;

    // Configuration registers.
    pfrm_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Shared divider, used for the flow and then for the window volume.
    assign div_start    = (state_reg == S_FLOW_START) || (state_reg == S_VOL_START);
    assign div_dividend = (state_reg == S_FLOW_START) ? flow_num_reg : vol_num_reg;

    pfrm_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  ((state_reg == S_FLOW_START) ? den_reg : DEN_W'(cfg.cal_factor_q8)),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    // Sample update: falling edge first, then the tick, then the window test.
    always_comb
    begin
        in_ready    = (state_reg == S_IDLE);
        in_fire     = in_valid && in_ready;
        edge_seen   = prev_level_reg && !in_data.pin_level && (count_reg != COUNT_MAX);
        count_upd   = count_reg + COUNT_WIDTH'(edge_seen);
        elapsed_upd = elapsed_reg +
                      16'(in_data.ms_tick && (elapsed_reg != pfrm_pkg::ELAPSED_MAX));
        window_done = (elapsed_upd > cfg.window_ms);
        cal_zero    = (cfg.cal_factor_q8 == 16'd0);
        out_free    = !out_valid_reg || out_ready;
        total_sum   = SUM_W'(total_reg) + SUM_W'(vol_q_reg);
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (in_data.op == pfrm_pkg::OP_SAMPLE) && window_done)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:       state_next = S_FLOW_START;
            S_FLOW_START: state_next = S_FLOW_WAIT;
            S_FLOW_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = S_VOL_START;
                end
            end
            S_VOL_START:  state_next = S_VOL_WAIT;
            S_VOL_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = S_ACCUM;
                end
            end
            S_ACCUM:      state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    // Control state and running counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            prev_level_reg <= 1'b1;
            count_reg      <= '0;
            elapsed_reg    <= '0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Result beat enters on the hand-off and leaves when taken.
            if ((state_reg == S_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (in_fire)
            begin
                if (in_data.op == pfrm_pkg::OP_CLEAR)
                begin
                    count_reg   <= '0;
                    elapsed_reg <= '0;
                    total_reg   <= '0;
                end
                else
                begin
                    prev_level_reg <= in_data.pin_level;
                    count_reg      <= count_upd;
                    elapsed_reg    <= elapsed_upd;
                end
            end

            // Saturating accumulation of the window volume.
            if (state_reg == S_ACCUM)
            begin
                if (cal_zero || (total_sum > SUM_W'(TOTAL_MAX)))
                begin
                    total_reg <= TOTAL_MAX;
                end
                else
                begin
                    total_reg <= total_sum[TOTAL_WIDTH-1:0];
                end
            end

            // Restart the window once the result is handed off.
            if ((state_reg == S_EMIT) && out_free)
            begin
                count_reg     <= '0;
                elapsed_reg   <= '0;
            end
        end
    end

    // Operand products, quotients and the result register.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD)
        begin
            flow_num_reg <= NUM_W'(count_reg) * NUM_W'(pfrm_pkg::FLOW_NUM_MULT);
            vol_num_reg  <= NUM_W'(count_reg) * NUM_W'(pfrm_pkg::VOL_NUM_MULT);
            den_reg      <= DEN_W'(elapsed_reg) * DEN_W'(cfg.cal_factor_q8);
        end

        if ((state_reg == S_FLOW_WAIT) && div_stat.done)
        begin
            if (cal_zero || (div_quotient > NUM_W'(pfrm_pkg::FLOW_MAX)))
            begin
                flow_q_reg <= pfrm_pkg::FLOW_MAX;
            end
            else
            begin
                flow_q_reg <= div_quotient[23:0];
            end
        end

        if ((state_reg == S_VOL_WAIT) && div_stat.done)
        begin
            vol_q_reg <= div_quotient;
        end

        if ((state_reg == S_EMIT) && out_free)
        begin
            out_data_reg.flow_ml_per_min   <= flow_q_reg;
            out_data_reg.total_volume_ul   <= 48'(64'(total_reg));
            out_data_reg.pulses_in_window  <= 16'(count_reg);
            out_data_reg.elapsed_window_ms <= elapsed_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/pfrm_checker.sv
// ----------------------------------------------------------------------------
// Pulse flow rate meter port checker
// Concurrent checks on the top-level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module pfrm_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           in_ready,
    input  wire pfrm_pkg::in_t  in_data,
    input  wire logic           out_valid,
    input  wire logic           out_ready,
    input  wire pfrm_pkg::out_t out_data,
    input  wire logic           pready
);

    // A waiting input beat holds its value until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input beat changed while waiting");

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // A finished window is always at least one millisecond long.
    a_elapsed_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.elapsed_window_ms != 16'd0))
        else $error("result reports an empty window");

    // A new result comes only after the input was held off for the computation.
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a computation phase");

    // The register port never inserts wait states.
    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind pulse_flow_rate_meter_unit pfrm_checker u_pfrm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .pready    (pready)
);

`default_nettype wire
